/* sv/sutt_pkg.sv */
// Shared constants, status codes and control types of the universe table.
package sutt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;
  localparam int UNI_W       = 15;
  localparam int STAT_W      = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_UPDATE = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
  } dp_stat_t;

endpackage

/* sv/sutt_ctrl.sv */
// Controller state machine: sequences capture and update of one beat.
module sutt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sutt_pkg::dp_stat_t dp_stat,
  output sutt_pkg::ctl_cmd_t cmd,
  output logic              busy,
  output logic              out_valid,
  output logic              full_seen
);

  sutt_pkg::state_t state_r, state_nxt;
  logic             valid_r, valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sutt_pkg::S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    busy        = 1'b0;
    unique case (state_r)
      sutt_pkg::S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = sutt_pkg::S_UPDATE;
        end
      end
      sutt_pkg::S_UPDATE: begin
        busy       = 1'b1;
        cmd.update = 1'b1;
        valid_nxt  = 1'b1;
        state_nxt  = sutt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = sutt_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = valid_r;
  assign full_seen = dp_stat.full;

endmodule

/* sv/sutt_dp.sv */
// Datapath: sorted table, parallel compare, shift insert and result registers.
module sutt_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sutt_pkg::ctl_cmd_t            cmd,
  input  logic                          in_action,
  input  logic [sutt_pkg::UNI_W-1:0]    in_universe,
  input  logic [sutt_pkg::IDX_W-1:0]    in_entry_index,
  output sutt_pkg::dp_stat_t            dp_stat,
  output logic [sutt_pkg::STAT_W-1:0]   out_status,
  output logic [sutt_pkg::IDX_W-1:0]    out_position,
  output logic [sutt_pkg::UNI_W-1:0]    out_entry_value,
  output logic [sutt_pkg::CNT_W-1:0]    out_entry_count
);

  localparam int D = sutt_pkg::TABLE_DEPTH;

  logic [sutt_pkg::UNI_W-1:0]  table_r [D];
  logic [sutt_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                        act_r;
  logic [sutt_pkg::UNI_W-1:0]  uni_r;
  logic [sutt_pkg::IDX_W-1:0]  idx_r;
  logic [D-1:0]                lt_r, eq_r;
  logic [D-1:0]                lt_nxt, eq_nxt;

  logic [sutt_pkg::IDX_W-1:0]  pos;
  logic                        full, present, do_insert, idx_ok;
  sutt_pkg::status_t           status_nxt;
  logic [sutt_pkg::IDX_W-1:0]  position_nxt;
  logic [sutt_pkg::UNI_W-1:0]  value_nxt;

  always_comb begin
    for (int i = 0; i < D; i++) begin
      lt_nxt[i] = (sutt_pkg::CNT_W'(i) < count_r) && (table_r[i] < in_universe);
      eq_nxt[i] = (sutt_pkg::CNT_W'(i) < count_r) && (table_r[i] == in_universe);
    end
  end

  always_comb begin
    pos = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (!lt_r[i]) begin
        pos = sutt_pkg::IDX_W'(i);
      end
    end
  end

  assign full    = (count_r == sutt_pkg::CNT_W'(D));
  assign present = |eq_r;
  assign idx_ok  = ({1'b0, idx_r} < count_r);
  assign do_insert = cmd.update && (act_r == sutt_pkg::ACT_ADD) && !full && !present;
  assign dp_stat.full = full;

  always_comb begin
    count_nxt    = count_r;
    position_nxt = '0;
    value_nxt    = '0;
    if (act_r == sutt_pkg::ACT_READ) begin
      if (idx_ok) begin
        status_nxt = sutt_pkg::ST_READ_OK;
        value_nxt  = table_r[idx_r];
      end else begin
        status_nxt = sutt_pkg::ST_BAD_INDEX;
      end
    end else if (full) begin
      status_nxt = sutt_pkg::ST_FULL;
    end else if (present) begin
      status_nxt   = sutt_pkg::ST_PRESENT;
      position_nxt = pos;
    end else begin
      status_nxt   = sutt_pkg::ST_INSERTED;
      position_nxt = pos;
      count_nxt    = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.update) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      uni_r <= in_universe;
      idx_r <= in_entry_index;
      lt_r  <= lt_nxt;
      eq_r  <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < D; i++) begin
        if (sutt_pkg::IDX_W'(i) == pos) begin
          table_r[i] <= uni_r;
        end else if ((i > 0) && (sutt_pkg::IDX_W'(i) > pos)) begin
          table_r[i] <= table_r[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_status      <= status_nxt;
      out_position    <= position_nxt;
      out_entry_value <= value_nxt;
      out_entry_count <= count_nxt;
    end
  end

endmodule

/* sv/sorted_unique_universe_table_core.sv */
// Top level of the sorted unique universe table.
// A beat accepted in idle is compared into the capture registers; in the update state
// the table is shift inserted and the result and its strobe registered. No new beat is taken while busy.
// Reset (synchronous, rst_n low) empties the table and drops any pending result.
// The receiver cannot stall: each result shows for exactly one cycle.
module sorted_unique_universe_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [sutt_pkg::UNI_W-1:0]    in_universe,
  input  logic [sutt_pkg::IDX_W-1:0]    in_entry_index,
  output logic                          out_valid,
  output logic [sutt_pkg::STAT_W-1:0]   out_status,
  output logic [sutt_pkg::IDX_W-1:0]    out_position,
  output logic [sutt_pkg::UNI_W-1:0]    out_entry_value,
  output logic [sutt_pkg::CNT_W-1:0]    out_entry_count
);

  sutt_pkg::ctl_cmd_t cmd;
  sutt_pkg::dp_stat_t dp_stat;
  logic               full_seen;

  sutt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dp_stat   (dp_stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .full_seen (full_seen)
  );

  sutt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_action       (in_action),
    .in_universe     (in_universe),
    .in_entry_index  (in_entry_index),
    .dp_stat         (dp_stat),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_value (out_entry_value),
    .out_entry_count (out_entry_count)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= sutt_pkg::CNT_W'(sutt_pkg::TABLE_DEPTH)))
    else $error("entry count beyond table depth");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sutt_pkg::ST_INSERTED) |->
      (out_entry_count != '0 && !(full_seen && out_entry_count == '0)))
    else $error("insert reported with empty table");
`endif

endmodule

/* test/utab_tb_pkg.sv */
// Scoreboard package: predicts universe table replies and checks the DUT against them.
package utab_tb_pkg;
  import sutt_pkg::*;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] position;
    logic [UNI_W-1:0] entry_value;
    logic [CNT_W-1:0] entry_count;
  } table_reply_t;

  class utab_scoreboard;
    logic [UNI_W-1:0] slots [TABLE_DEPTH];
    int unsigned      used;
    table_reply_t     pending_replies [$];
    int unsigned      mismatches;
    int unsigned      strays;
    int unsigned      reported;
    int unsigned      status_seen [5];

    function new();
      foreach (slots[i]) slots[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      used = 0;
      mismatches = 0;
      strays = 0;
      reported = 0;
    endfunction

    function bit holds(logic [UNI_W-1:0] uni);
      for (int i = 0; i < used; i++)
        if (slots[i] == uni) return 1'b1;
      return 1'b0;
    endfunction

    function void note_beat(action_t act, logic [UNI_W-1:0] uni, logic [IDX_W-1:0] idx);
      table_reply_t r;
      int unsigned  pos;
      r.status      = ST_INSERTED;
      r.position    = '0;
      r.entry_value = '0;
      if (act == ACT_READ) begin
        if (idx < used) begin
          r.status      = ST_READ_OK;
          r.entry_value = slots[idx];
        end else begin
          r.status = ST_BAD_INDEX;
        end
      end else if (used >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < used && slots[pos] < uni) pos++;
        if (pos < used && slots[pos] == uni) begin
          r.status = ST_PRESENT;
        end else begin
          for (int k = used; k > pos; k--) slots[k] = slots[k-1];
          slots[pos] = uni;
          used++;
        end
        r.position = pos[IDX_W-1:0];
      end
      r.entry_count = used[CNT_W-1:0];
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [STAT_W-1:0] st, logic [IDX_W-1:0] pos,
                              logic [UNI_W-1:0] val, logic [CNT_W-1:0] cnt);
      table_reply_t e;
      if (pending_replies.size() == 0) begin
        strays++;
        reported++;
        if (reported <= 10)
          $display("unexpected result: status %0d pos %0d value %0d count %0d",
                   st, pos, val, cnt);
        return;
      end
      e = pending_replies.pop_front();
      if (st !== e.status || pos !== e.position || val !== e.entry_value ||
          cnt !== e.entry_count) begin
        mismatches++;
        reported++;
        if (reported <= 10)
          $display({"mismatch: expected status %0d pos %0d value %0d count %0d,",
                    " got %0d %0d %0d %0d"},
                   e.status, e.position, e.entry_value, e.entry_count, st, pos, val, cnt);
      end else begin
        status_seen[e.status]++;
      end
    endfunction

    function int unsigned failures();
      return mismatches + strays + pending_replies.size();
    endfunction
  endclass

endpackage

/* test/tb_top.sv */
// Top of the universe table testbench: clock, reset, beat driver and result monitor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sutt_pkg::*;
  import utab_tb_pkg::*;

  localparam int RANDOM_BEATS = 1800;
  localparam int CYCLE_LIMIT  = 200000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             in_action = 1'b0;
  logic [UNI_W-1:0] in_universe = '0;
  logic [IDX_W-1:0] in_entry_index = '0;
  logic             out_valid;
  logic [STAT_W-1:0] out_status;
  logic [IDX_W-1:0] out_position;
  logic [UNI_W-1:0] out_entry_value;
  logic [CNT_W-1:0] out_entry_count;

  utab_scoreboard sb = new();
  int unsigned    idle_pct = 0;
  int unsigned    beats_sent = 0;
  int unsigned    cycles = 0;
  int unsigned    phase_idle [4] = '{0, 70, 0, 14};

  sorted_unique_universe_table_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_universe     (in_universe),
    .in_entry_index  (in_entry_index),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_value (out_entry_value),
    .out_entry_count (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_reply(out_status, out_position, out_entry_value, out_entry_count);
  end

  task automatic send_beat(action_t act, logic [UNI_W-1:0] uni, logic [IDX_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start          <= 1'b0;
      in_action      <= 1'($urandom);
      in_universe    <= UNI_W'($urandom);
      in_entry_index <= IDX_W'($urandom);
      @(negedge clk);
    end
    start          <= 1'b1;
    in_action      <= act;
    in_universe    <= uni;
    in_entry_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    beats_sent++;
    sb.note_beat(act, uni, idx);
  endtask

  task automatic random_beat(int unsigned n);
    action_t          act;
    logic [UNI_W-1:0] uni;
    logic [IDX_W-1:0] idx;
    int unsigned      roll;
    int unsigned      fill_goal;
    act       = ($urandom_range(99) < 40) ? ACT_READ : ACT_ADD;
    uni       = UNI_W'($urandom);
    idx       = IDX_W'($urandom);
    roll      = $urandom_range(99);
    fill_goal = (n * 40) / RANDOM_BEATS;
    if (act == ACT_ADD) begin
      if (sb.used < fill_goal && roll < 70) begin
        if (sb.used > 0 && roll < 12)
          uni = sb.slots[$urandom_range(sb.used - 1)] + 15'd1;
        else if (sb.used > 0 && roll < 25)
          uni = sb.slots[$urandom_range(sb.used - 1)] - 15'd1;
        else if (roll < 30)
          uni = (roll & 1) ? '1 : '0;
        while (sb.holds(uni)) uni = UNI_W'($urandom);
      end else if (sb.used > 0 && roll < 85) begin
        uni = sb.slots[$urandom_range(sb.used - 1)];
      end
    end else if (roll < 75) begin
      idx = $urandom_range(sb.used < TABLE_DEPTH ? sb.used : TABLE_DEPTH - 1);
    end
    send_beat(act, uni, idx);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table, extremes, duplicates and neighbors
    send_beat(ACT_READ, UNI_W'($urandom), 5'd0);
    send_beat(ACT_READ, UNI_W'($urandom), 5'd31);
    send_beat(ACT_ADD, 15'd16384, IDX_W'($urandom));
    send_beat(ACT_ADD, 15'd0, IDX_W'($urandom));
    send_beat(ACT_ADD, 15'd32767, IDX_W'($urandom));
    send_beat(ACT_ADD, 15'd0, IDX_W'($urandom));
    send_beat(ACT_ADD, 15'd32767, IDX_W'($urandom));
    send_beat(ACT_ADD, 15'd16383, IDX_W'($urandom));
    send_beat(ACT_ADD, 15'd16385, IDX_W'($urandom));
    send_beat(ACT_ADD, 15'd21845, IDX_W'($urandom));
    send_beat(ACT_ADD, 15'd10922, IDX_W'($urandom));
    for (int i = 0; i < 8; i++) send_beat(ACT_READ, UNI_W'($urandom), i[IDX_W-1:0]);
    send_beat(ACT_READ, UNI_W'($urandom), 5'd31);
    send_beat(ACT_ADD, 15'd16384, IDX_W'($urandom));

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      for (int i = 0; i < RANDOM_BEATS / 4; i++)
        random_beat(p * (RANDOM_BEATS / 4) + i);
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("%0d beats: %0d inserted, %0d duplicates, %0d refused as full,",
             beats_sent, sb.status_seen[ST_INSERTED], sb.status_seen[ST_PRESENT],
             sb.status_seen[ST_FULL]);
    $display("%0d reads in range, %0d out of range; table ended with %0d entries",
             sb.status_seen[ST_READ_OK], sb.status_seen[ST_BAD_INDEX], sb.used);
    if (sb.failures() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
sv/sutt_pkg.sv
sv/sutt_ctrl.sv
sv/sutt_dp.sv
sv/sorted_unique_universe_table_core.sv
test/utab_tb_pkg.sv
test/tb_top.sv
